// ----- hw/rtl/spq_pkg.sv -----
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH   = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PRIO_W  = 8;
    localparam int VAL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  val;
    } t_entry;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  val;
    } t_cell_cmd;

endpackage

// ----- hw/rtl/spq_ifs.sv -----
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [spq_pkg::PRIO_W-1:0] priority_req;
    logic [spq_pkg::VAL_W-1:0]  value;

    modport source (output valid, req_type, priority_req, value, input ready);
    modport sink   (input valid, req_type, priority_req, value, output ready);
endinterface

interface spq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::VAL_W-1:0]  removed_value;
    logic [spq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, status, removed_value, occupancy, input ready);
    modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted store: keeps, takes the new entry, or shifts from a neighbor.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_left_ge,
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_ge
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // stored entry ranks ahead of (or ties with) the incoming one
    assign o_ge    = i_occupied && (r_entry.prio >= i_cmd.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (!o_ge) begin
                if (i_left_ge) begin
                    n_entry.prio = i_cmd.prio;
                    n_entry.val  = i_cmd.val;
                end else begin
                    n_entry = i_left_entry;
                end
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue: top level with the cell chain, count and response register.
//
// Bounded queue of spq_pkg::DEPTH entries kept sorted highest priority first,
// equal priorities in arrival order. Every request transaction yields one
// response transaction with a status (ok, full, empty), the removed payload
// and the occupancy after the request. A request is served by a row of
// cells that all compare against the incoming priority and shift in
// parallel; the response appears in the output register on the next cycle.
// One request per cycle is sustained as long as responses are taken; the
// request side stalls only while a response waits in the output register.
module sorted_priority_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int CNT_W = spq_pkg::CNT_W;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    logic [spq_pkg::STAT_W-1:0] r_status;
    logic [spq_pkg::STAT_W-1:0] n_status;
    logic [spq_pkg::VAL_W-1:0]  r_removed;
    logic [spq_pkg::VAL_W-1:0]  n_removed;

    logic accept;
    logic full;
    logic empty;

    spq_pkg::t_cell_cmd cmd;
    spq_pkg::t_entry    w_entry [DEPTH];
    logic               w_ge    [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);

    assign cmd.ins  = accept && (i_req.req_type == spq_pkg::REQ_INSERT) && !full;
    assign cmd.rem  = accept && (i_req.req_type == spq_pkg::REQ_REMOVE) && !empty;
    assign cmd.prio = i_req.priority_req;
    assign cmd.val  = i_req.value;

    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        logic            left_ge;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_ge    = 1'b1;
            assign left_entry = w_entry[0];
        end else begin : g_mid
            assign left_ge    = w_ge[g-1];
            assign left_entry = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_entry = w_entry[g];
        end else begin : g_body
            assign right_entry = w_entry[g+1];
        end

        spq_cell u_slot (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_left_ge    (left_ge),
            .i_left_entry (left_entry),
            .i_right_entry(right_entry),
            .o_entry      (w_entry[g]),
            .o_ge         (w_ge[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = spq_pkg::STATUS_OK;
        n_removed = '0;
        if (i_req.req_type == spq_pkg::REQ_INSERT) begin
            if (full) begin
                n_status = spq_pkg::STATUS_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = spq_pkg::STATUS_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                n_removed = w_entry[0].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.occupancy     = spq_pkg::OCC_W'(r_count);

endmodule
